FILE: rtl/selective_repeat_receiver_core_defines.svh
// assertion macros shared by the receiver rtl
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SRR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRR_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SRR_ASSERT(lbl, clk, rst, prop, msg)
`define SRR_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: rtl/srr_pkg.sv
// shared constants, types and tables of the selective repeat receiver
package srr_pkg;

   localparam int STORE_DEPTH   = 64;
   localparam int WINDOW_MAX    = 32;
   localparam int PAYLOAD_BYTES = 20;

   localparam int SEQ_W      = 31;
   localparam int SUM_W      = 32;
   localparam int WIN_W      = 6;
   localparam int LO_W       = 64;
   localparam int MID_W      = 64;
   localparam int HI_W       = 32;
   localparam int DATA_W     = LO_W + MID_W + HI_W;
   localparam int PAY_W      = PAYLOAD_BYTES * 8;
   localparam int SLOT_W     = $clog2(STORE_DEPTH);
   localparam int CSUM_STEPS = PAYLOAD_BYTES + 1;
   localparam int STEP_W     = $clog2(CSUM_STEPS);
   localparam int AHEAD_W    = $clog2(WINDOW_MAX + 1);
   localparam int CNT_W      = WIN_W;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CSUM,
      ST_CHECK,
      ST_ACK,
      ST_READ,
      ST_DELIVER
   } state_type;

   typedef enum logic {
      KIND_ACK  = 1'b0,
      KIND_DATA = 1'b1
   } kind_type;

   typedef struct packed {
      logic             start;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] ack;
   } csum_ctl_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] pair_sum;
   } csum_sts_type;

   typedef logic [SLOT_W-1:0] slot_tab_type [2**AHEAD_W];

   // distance ahead of the expected packet reduced to a slot offset
   function automatic slot_tab_type make_slot_tab();
      slot_tab_type t;
      for (int i = 0; i < 2**AHEAD_W; i++) begin
         t[i] = SLOT_W'(i % STORE_DEPTH);
      end
      return t;
   endfunction

   localparam slot_tab_type AHEAD_SLOT = make_slot_tab();

endpackage

FILE: rtl/srr_req_if.sv
// packet channel into the receiver
interface srr_req_if;
   import srr_pkg::*;

   logic             valid;
   logic             ready;
   logic [SEQ_W-1:0] seq_num;
   logic [SEQ_W-1:0] ack_field;
   logic [SUM_W-1:0] sum_field;
   logic [LO_W-1:0]  payload_lo;
   logic [MID_W-1:0] payload_mid;
   logic [HI_W-1:0]  payload_hi;

   modport source (
      output valid, seq_num, ack_field, sum_field, payload_lo, payload_mid, payload_hi,
      input  ready
   );

   modport sink (
      input  valid, seq_num, ack_field, sum_field, payload_lo, payload_mid, payload_hi,
      output ready
   );
endinterface

FILE: rtl/srr_rsp_if.sv
// ack and delivery channel out of the receiver
interface srr_rsp_if;
   import srr_pkg::*;

   logic             valid;
   logic             ready;
   logic             kind;
   logic [SEQ_W-1:0] ack_seq;
   logic [SEQ_W-1:0] ack_number;
   logic [SUM_W-1:0] ack_sum;
   logic [LO_W-1:0]  data_lo;
   logic [MID_W-1:0] data_mid;
   logic [HI_W-1:0]  data_hi;
   logic             last;

   modport source (
      output valid, kind, ack_seq, ack_number, ack_sum, data_lo, data_mid, data_hi, last,
      input  ready
   );

   modport sink (
      input  valid, kind, ack_seq, ack_number, ack_sum, data_lo, data_mid, data_hi, last,
      output ready
   );
endinterface

FILE: rtl/srr_csum.sv
// iterative checksum unit: one shared 32-bit adder, one term per cycle
module srr_csum (
   input  logic                         clock,
   input  logic                         reset,
   input  srr_pkg::csum_ctl_type        ctl,
   input  logic [srr_pkg::PAY_W-1:0]    payload,
   output srr_pkg::csum_sts_type        sts
);
   import srr_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  pair_ff, pair_in;
   logic [SEQ_W-1:0]  ack_ff, ack_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;
   logic [SUM_W-1:0]  operand;
   logic [SUM_W-1:0]  adder;

   // first step adds the ack number, the rest one sign-extended byte each
   assign operand = (step_ff == '0) ? {1'b0, ack_ff}
                                    : {{(SUM_W-8){pay_ff[7]}}, pay_ff[7:0]};
   assign adder   = acc_ff + operand;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      pair_in = pair_ff;
      ack_in  = ack_ff;
      pay_in  = pay_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = '0;
         acc_in  = {1'b0, ctl.seq};
         ack_in  = ctl.ack;
         pay_in  = payload;
      end else if (busy_ff) begin
         acc_in  = adder;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == '0) begin
            pair_in = adder;
         end else begin
            pay_in = pay_ff >> 8;
         end
         if (step_ff == STEP_W'(CSUM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      acc_ff  <= acc_in;
      pair_ff <= pair_in;
      ack_ff  <= ack_in;
      pay_ff  <= pay_in;
   end

   assign sts.done     = done_ff;
   assign sts.sum      = acc_ff;
   assign sts.pair_sum = pair_ff;

endmodule

FILE: rtl/selective_repeat_receiver_core.sv
// selective repeat receiver: checksum, window check, ack, store and in-order delivery
//
//   channel   direction  handshake        carries
//   req_if    in         valid / ready    seq, ack, checksum, 20-byte payload
//   rsp_if    out        valid / ready    ack or delivered payload, last flag
//   csr_*     in         write enable     window size, 6 bits
//
// a packet passes through checksum, window check and ack; the shared checksum adder
// walks seq+ack and then one payload byte per cycle;
// each delivery goes through store read, then output load
// req_if.ready is high only in idle; results leave through one output register,
// so a stalled rsp_if holds the sequencer but never drops or repeats a transfer
// synchronous reset sets expected seq to 1, clears all received marks at once
`include "selective_repeat_receiver_core_defines.svh"
module selective_repeat_receiver_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [srr_pkg::WIN_W-1:0]  csr_wdata,
   srr_req_if.sink                    req_if,
   srr_rsp_if.source                  rsp_if
);
   import srr_pkg::*;

   state_type          state_ff, state_in;
   logic [WIN_W-1:0]   window_ff;
   logic [SEQ_W-1:0]   exp_ff, exp_in;
   logic [SLOT_W-1:0]  exp_slot_ff, exp_slot_in;
   logic               marks_ff [STORE_DEPTH];
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [SEQ_W-1:0]   ack_ff, ack_in;
   logic [SUM_W-1:0]   got_ff, got_in;
   logic [PAY_W-1:0]   pay_ff, pay_in;
   logic               in_win_ff, in_win_in;
   logic               is_exp_ff, is_exp_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [SEQ_W-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [SEQ_W-1:0]   rsp_ack_ff, rsp_ack_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [PAY_W-1:0]   store_mem [STORE_DEPTH];
   logic [PAY_W-1:0]   rd_data_ff;
   logic               mem_we;
   logic               mem_re;
   logic               mark_set;
   logic               mark_clr;

   csum_ctl_type       csum_ctl;
   csum_sts_type       csum_sts;

   logic [WIN_W-1:0]   win_eff;
   logic [SEQ_W-1:0]   ahead;
   logic [SEQ_W-1:0]   behind;
   logic               in_win;
   logic               old_pkt;
   logic [SLOT_W:0]    slot_sum;
   logic [SLOT_W-1:0]  seq_slot;
   logic [SLOT_W-1:0]  exp_slot_nx;
   logic               out_free;
   logic               more;

   srr_csum u_csum (
      .clock   (clock),
      .reset   (reset),
      .ctl     (csum_ctl),
      .payload (pay_in),
      .sts     (csum_sts)
   );

   // window of 0 acts as 1, anything above the maximum is clipped
   always_comb begin
      if (window_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (window_ff > WIN_W'(WINDOW_MAX)) begin
         win_eff = WIN_W'(WINDOW_MAX);
      end else begin
         win_eff = window_ff;
      end
   end

   assign ahead   = seq_ff - exp_ff;
   assign behind  = exp_ff - seq_ff;
   assign in_win  = ahead < SEQ_W'(win_eff);
   assign old_pkt = (behind != '0) && (behind <= SEQ_W'(win_eff));

   // slot of an in-window packet, from the expected slot plus the reduced distance
   assign slot_sum = {1'b0, exp_slot_ff} + {1'b0, AHEAD_SLOT[ahead[AHEAD_W-1:0]]};
   assign seq_slot = (slot_sum >= (SLOT_W+1)'(STORE_DEPTH))
                   ? SLOT_W'(slot_sum - (SLOT_W+1)'(STORE_DEPTH))
                   : SLOT_W'(slot_sum);

   assign exp_slot_nx = (exp_slot_ff == SLOT_W'(STORE_DEPTH - 1))
                      ? '0 : exp_slot_ff + SLOT_W'(1);

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign more     = ((cnt_ff + CNT_W'(1)) < win_eff)
                  && (32'(cnt_ff + CNT_W'(1)) < STORE_DEPTH)
                  && marks_ff[exp_slot_nx];

   assign req_if.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      exp_slot_in  = exp_slot_ff;
      seq_in       = seq_ff;
      ack_in       = ack_ff;
      got_in       = got_ff;
      pay_in       = pay_ff;
      in_win_in    = in_win_ff;
      is_exp_in    = is_exp_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_ack_in   = rsp_ack_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mark_set     = 1'b0;
      mark_clr     = 1'b0;
      csum_ctl     = '{start: 1'b0, seq: req_if.seq_num, ack: req_if.ack_field};

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               seq_in         = req_if.seq_num;
               ack_in         = req_if.ack_field;
               got_in         = req_if.sum_field;
               pay_in         = PAY_W'({req_if.payload_hi, req_if.payload_mid,
                                        req_if.payload_lo});
               csum_ctl.start = 1'b1;
               state_in       = ST_CSUM;
            end
         end
         ST_CSUM: begin
            if (csum_sts.done) begin
               // corrupt packet: silently dropped
               state_in = (csum_sts.sum == got_ff) ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            in_win_in = in_win;
            is_exp_in = (ahead == '0);
            slot_in   = seq_slot;
            state_in  = (in_win || old_pkt) ? ST_ACK : ST_IDLE;
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_seq_in   = seq_ff;
               rsp_ack_in   = ack_ff;
               rsp_sum_in   = csum_sts.pair_sum;
               rsp_data_in  = '0;
               rsp_last_in  = !(in_win_ff && is_exp_ff);
               // duplicate inside the window keeps the first copy
               if (in_win_ff && !marks_ff[slot_ff]) begin
                  mem_we   = 1'b1;
                  mark_set = 1'b1;
               end
               cnt_in   = '0;
               state_in = (in_win_ff && is_exp_ff) ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DATA;
               rsp_seq_in   = '0;
               rsp_ack_in   = '0;
               rsp_sum_in   = '0;
               rsp_data_in  = DATA_W'(rd_data_ff);
               rsp_last_in  = !more;
               mark_clr     = 1'b1;
               exp_in       = exp_ff + SEQ_W'(1);
               exp_slot_in  = exp_slot_nx;
               cnt_in       = cnt_ff + CNT_W'(1);
               state_in     = more ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         exp_ff       <= SEQ_W'(1);
         exp_slot_ff  <= SLOT_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            marks_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         exp_slot_ff  <= exp_slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         if (mark_set) begin
            marks_ff[slot_ff] <= 1'b1;
         end
         if (mark_clr) begin
            marks_ff[exp_slot_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      ack_ff      <= ack_in;
      got_ff      <= got_in;
      pay_ff      <= pay_in;
      in_win_ff   <= in_win_in;
      is_exp_ff   <= is_exp_in;
      slot_ff     <= slot_in;
      cnt_ff      <= cnt_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // payload store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[slot_ff] <= pay_ff;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[exp_slot_ff];
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.kind       = rsp_kind_ff;
   assign rsp_if.ack_seq    = rsp_seq_ff;
   assign rsp_if.ack_number = rsp_ack_ff;
   assign rsp_if.ack_sum    = rsp_sum_ff;
   assign rsp_if.data_lo    = rsp_data_ff[LO_W-1:0];
   assign rsp_if.data_mid   = rsp_data_ff[LO_W+MID_W-1:LO_W];
   assign rsp_if.data_hi    = rsp_data_ff[DATA_W-1:LO_W+MID_W];
   assign rsp_if.last       = rsp_last_ff;

   `SRR_ASSERT(a_deliver_marked, clock, reset, (state_ff == ST_DELIVER) |-> marks_ff[exp_slot_ff], "delivery from an unmarked slot")
   `SRR_ASSERT(a_expected_step, clock, reset, (exp_ff == $past(exp_ff)) || (exp_ff == $past(exp_ff) + SEQ_W'(1)), "expected seq jumped")
   `SRR_ASSERT_NEVER(a_slot_range, clock, reset, 32'(exp_slot_ff) >= STORE_DEPTH, "expected slot out of range")
   `SRR_ASSERT(a_done_in_csum, clock, reset, csum_sts.done |-> (state_ff == ST_CSUM), "checksum done outside its wait")
   `SRR_ASSERT(a_delivery_bound, clock, reset, (state_ff == ST_DELIVER) |-> (cnt_ff < win_eff), "more deliveries than the window")

endmodule
